@@ rtl/core/vap_pkg.sv @@
// Shared types, register indexes and helpers for the axial volume projection.
// Used by the scan counter, the pixel memory and the top level.
package vap_pkg;

   // Default volume limits.
   localparam int unsigned MAX_COLUMNS_DEF = 256;
   localparam int unsigned MAX_ROWS_DEF    = 256;
   localparam int unsigned MAX_SLICES_DEF  = 255;

   // Field and register widths.
   localparam int unsigned VOXEL_W     = 16;
   localparam int unsigned DEPTH_W     = 8;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 9;
   // Holds any clamped dimension up to 4096.
   localparam int unsigned LIM_W       = 13;

   localparam logic [CSR_INDEX_W-1:0] CSR_MODE    = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMNS = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_ROWS    = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_SLICES  = CSR_INDEX_W'(3);

   typedef enum logic [1:0] {
      MODE_FIRST_DEPTH = 2'd0,
      MODE_FIRST_VALUE = 2'd1,
      MODE_MAX_DEPTH   = 2'd2,
      MODE_MAX_VALUE   = 2'd3
   } mode_type;

   // One memory word: running value and depth (z+1, zero means no hit).
   typedef struct packed {
      logic [VOXEL_W-1:0] value;
      logic [DEPTH_W-1:0] depth;
   } entry_type;

   // Position flags of one voxel, from the scan counter to the update stage.
   typedef struct packed {
      logic               first_slice;
      logic               last_slice;
      logic               end_image;
      logic [DEPTH_W-1:0] depth;
   } pos_type;

   // A zero dimension counts as one, anything above the limit as the limit.
   function automatic logic [LIM_W-1:0] clamp_dim(input logic [CSR_DATA_W-1:0] v,
                                                  input int unsigned hi);
      logic [LIM_W-1:0] r;
      if (v == '0) begin
         r = LIM_W'(1);
      end else if (32'(v) > hi) begin
         r = LIM_W'(hi);
      end else begin
         r = LIM_W'(v);
      end
      return r;
   endfunction

endpackage

@@ rtl/core/vap_scan.sv @@
// Configuration registers and the column, row and slice counters that place
// each voxel beat. Depends on vap_pkg.
module vap_scan import vap_pkg::*; #(
   parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEF,
   parameter int unsigned MAX_ROWS    = MAX_ROWS_DEF,
   parameter int unsigned MAX_SLICES  = MAX_SLICES_DEF,
   parameter int unsigned ADDR_W      = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   step,
   output logic [ADDR_W-1:0]      addr,
   output pos_type                pos,
   output mode_type               mode
);

   localparam int unsigned COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int unsigned ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   mode_type           mode_ff, mode_in;
   logic [LIM_W-1:0]   cols_lim_ff, cols_lim_in;
   logic [LIM_W-1:0]   rows_lim_ff, rows_lim_in;
   logic [LIM_W-1:0]   slices_lim_ff, slices_lim_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [DEPTH_W-1:0] slice_ff, slice_in;
   logic               last_col, last_row, last_slice;

   assign last_col   = (LIM_W'(col_ff) + LIM_W'(1)) >= cols_lim_ff;
   assign last_row   = (LIM_W'(row_ff) + LIM_W'(1)) >= rows_lim_ff;
   assign last_slice = (LIM_W'(slice_ff) + LIM_W'(1)) >= slices_lim_ff;

   assign addr = base_ff + ADDR_W'(col_ff);
   assign mode = mode_ff;

   always_comb begin
      pos.first_slice = (slice_ff == '0);
      pos.last_slice  = last_slice;
      pos.end_image   = last_row && last_col;
      pos.depth       = slice_ff + DEPTH_W'(1);
   end

   always_comb begin
      mode_in       = mode_ff;
      cols_lim_in   = cols_lim_ff;
      rows_lim_in   = rows_lim_ff;
      slices_lim_in = slices_lim_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      base_in       = base_ff;
      slice_in      = slice_ff;
      if (csr_write) begin
         // Any write restarts the volume.
         case (csr_index)
            CSR_MODE:    mode_in       = mode_type'(csr_data[1:0]);
            CSR_COLUMNS: cols_lim_in   = clamp_dim(csr_data, MAX_COLUMNS);
            CSR_ROWS:    rows_lim_in   = clamp_dim(csr_data, MAX_ROWS);
            CSR_SLICES:  slices_lim_in = clamp_dim({1'b0, csr_data[7:0]}, MAX_SLICES);
            default:     ;
         endcase
         col_in   = '0;
         row_in   = '0;
         base_in  = '0;
         slice_in = '0;
      end else if (step) begin
         if (!last_col) begin
            col_in = col_ff + COL_W'(1);
         end else begin
            col_in = '0;
            if (!last_row) begin
               row_in  = row_ff + ROW_W'(1);
               base_in = base_ff + ADDR_W'(MAX_COLUMNS);
            end else begin
               row_in   = '0;
               base_in  = '0;
               slice_in = last_slice ? '0 : slice_ff + DEPTH_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_FIRST_DEPTH;
         cols_lim_ff   <= clamp_dim(CSR_DATA_W'(256), MAX_COLUMNS);
         rows_lim_ff   <= clamp_dim(CSR_DATA_W'(256), MAX_ROWS);
         slices_lim_ff <= clamp_dim(CSR_DATA_W'(255), MAX_SLICES);
         col_ff        <= '0;
         row_ff        <= '0;
         base_ff       <= '0;
         slice_ff      <= '0;
      end else begin
         mode_ff       <= mode_in;
         cols_lim_ff   <= cols_lim_in;
         rows_lim_ff   <= rows_lim_in;
         slices_lim_ff <= slices_lim_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         base_ff       <= base_in;
         slice_ff      <= slice_in;
      end
   end

endmodule

@@ rtl/core/vap_pixel_mem.sv @@
// Per-pixel memory of running value and depth, one read and one write port,
// registered read data. Depends on vap_pkg.
module vap_pixel_mem import vap_pkg::*; #(
   parameter int unsigned DEPTH  = 65536,
   parameter int unsigned ADDR_W = 16
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output entry_type         rd_entry,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  entry_type         wr_entry
);

   entry_type mem_ff [DEPTH];
   entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_entry;
      end
   end

   // Read-first: a read of the entry being written returns the old word.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_entry_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

@@ rtl/core/volume_axial_projection.sv @@
// Top level of the axial volume projection: scan counter, pixel memory,
// read-modify-write stage and result register. Depends on vap_pkg.
//
// Takes one voxel beat per clock in slice, row, column order and keeps a
// running value and depth per pixel in a single memory with one read and one
// write port. A beat reads its pixel entry in the cycle it is accepted, is
// updated in the update stage and written back when that stage moves on, and
// during the last slice its projected pixel lands in the result register at
// that same write-back edge. The result beat can be taken at the following edge.
// A pixel entry written in one cycle and read by the very next beat (a
// one-pixel image) is forwarded. The memory needs no clearing pass: the first
// slice writes every entry before it is read. The input stalls only while the
// result register is full, stalled and another result is due.
module volume_axial_projection import vap_pkg::*; #(
   parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEF,
   parameter int unsigned MAX_ROWS    = MAX_ROWS_DEF,
   parameter int unsigned MAX_SLICES  = MAX_SLICES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [VOXEL_W-1:0]     req_voxel_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [VOXEL_W-1:0]     rsp_projected_value,
   output logic                   rsp_end_of_image
);

   localparam int unsigned PIXELS = MAX_COLUMNS * MAX_ROWS;
   localparam int unsigned ADDR_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;

   logic              accept;
   logic [ADDR_W-1:0] scan_addr;
   pos_type           scan_pos;
   mode_type          mode;
   entry_type         rd_entry;

   logic               s1_valid_ff, s1_valid_in;
   logic [ADDR_W-1:0]  s1_addr_ff;
   pos_type            s1_pos_ff;
   logic [VOXEL_W-1:0] s1_voxel_ff;
   logic               s1_fwd_ff;
   entry_type          s1_fwd_entry_ff;
   logic               s1_adv;

   entry_type          old_entry, new_entry;
   logic               first_hit, depth_mode;
   logic [VOXEL_W-1:0] result;

   logic               out_valid_ff, out_valid_in;
   logic [VOXEL_W-1:0] out_value_ff;
   logic               out_end_ff;

   vap_scan #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS),
      .MAX_SLICES  (MAX_SLICES),
      .ADDR_W      (ADDR_W)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .step      (accept),
      .addr      (scan_addr),
      .pos       (scan_pos),
      .mode      (mode)
   );

   vap_pixel_mem #(
      .DEPTH  (PIXELS),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock    (clock),
      .rd_en    (accept),
      .rd_addr  (scan_addr),
      .rd_entry (rd_entry),
      .wr_en    (s1_adv),
      .wr_addr  (s1_addr_ff),
      .wr_entry (new_entry)
   );

   // The update stage moves on unless it holds a result and the result
   // register is full and stalled.
   assign s1_adv    = s1_valid_ff && !(s1_pos_ff.last_slice && out_valid_ff && rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign accept    = req_valid && !req_stall;

   assign first_hit  = (mode == MODE_FIRST_DEPTH) || (mode == MODE_FIRST_VALUE);
   assign depth_mode = (mode == MODE_FIRST_DEPTH) || (mode == MODE_MAX_DEPTH);
   assign old_entry  = s1_fwd_ff ? s1_fwd_entry_ff : rd_entry;

   always_comb begin
      new_entry = old_entry;
      if (s1_pos_ff.first_slice) begin
         if (first_hit && (s1_voxel_ff == '0)) begin
            new_entry.value = '0;
            new_entry.depth = '0;
         end else begin
            new_entry.value = s1_voxel_ff;
            new_entry.depth = DEPTH_W'(1);
         end
      end else if (first_hit) begin
         if ((s1_voxel_ff != '0) && (old_entry.depth == '0)) begin
            new_entry.value = s1_voxel_ff;
            new_entry.depth = s1_pos_ff.depth;
         end
      end else if (s1_voxel_ff > old_entry.value) begin
         new_entry.value = s1_voxel_ff;
         new_entry.depth = s1_pos_ff.depth;
      end
   end

   assign result = depth_mode ? VOXEL_W'(new_entry.depth) : new_entry.value;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_adv && s1_pos_ff.last_slice) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff      <= scan_addr;
         s1_pos_ff       <= scan_pos;
         s1_voxel_ff     <= req_voxel_value;
         // The memory returns the old word when the beat ahead writes the
         // same pixel at this edge, so take the updated word directly.
         s1_fwd_ff       <= s1_adv && (s1_addr_ff == scan_addr);
         s1_fwd_entry_ff <= new_entry;
      end
      if (s1_adv && s1_pos_ff.last_slice) begin
         out_value_ff <= result;
         out_end_ff   <= s1_pos_ff.end_image;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_projected_value = out_value_ff;
   assign rsp_end_of_image    = out_end_ff;

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s1_pos_ff.last_slice && out_valid_ff))
      else $error("input stalled without a blocked result");

   a_fwd_only_behind_write: assert property (@(posedge clock) disable iff (reset)
      (accept && s1_adv && (s1_addr_ff == scan_addr)) |=> (s1_fwd_ff && s1_valid_ff))
      else $error("back-to-back beat on one pixel not forwarded");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_pos_ff.last_slice) |=> out_valid_ff)
      else $error("last-slice beat left no result");

endmodule

@@ verif/volume_axial_projection_checker.sv @@
// Checker for the axial volume projection: follows register writes, predicts each
// projected pixel from accepted voxel beats and compares result beats in order.
// Depends on vap_pkg.
module volume_axial_projection_checker import vap_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [VOXEL_W-1:0]     req_voxel_value,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [VOXEL_W-1:0]     rsp_projected_value,
   input  logic                   rsp_end_of_image,
   output int unsigned            mismatch_count,
   output int unsigned            pixels_outstanding
);

   localparam int unsigned PIXELS = MAX_COLUMNS_DEF * MAX_ROWS_DEF;

   typedef struct packed {
      logic [VOXEL_W-1:0] value;
      logic               end_image;
   } pixel_type;

   mode_type              mode;
   logic [CSR_DATA_W-1:0] columns_reg;
   logic [CSR_DATA_W-1:0] rows_reg;
   logic [DEPTH_W-1:0]    slices_reg;
   int unsigned           column_pos;
   int unsigned           row_pos;
   int unsigned           slice_pos;
   logic [VOXEL_W-1:0]    best_value [PIXELS];
   logic [DEPTH_W-1:0]    best_depth [PIXELS];
   pixel_type             expected_pixels [$];

   task automatic report_mismatch(input string what);
      $display("projection mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   function automatic int unsigned limit_dim(input int unsigned v, input int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // Updates the running entry of the voxel's pixel and advances the scan
   // position. Returns 1 when the voxel lies in the last slice.
   function automatic bit project_voxel(input logic [VOXEL_W-1:0] v,
                                        output pixel_type pixel);
      int unsigned        cols;
      int unsigned        rows;
      int unsigned        slices;
      int unsigned        at;
      logic [DEPTH_W-1:0] depth;
      bit                 first_hit;
      bit                 last_col;
      bit                 last_row;
      bit                 last_slice;
      cols       = limit_dim(columns_reg, MAX_COLUMNS_DEF);
      rows       = limit_dim(rows_reg, MAX_ROWS_DEF);
      slices     = limit_dim(slices_reg, MAX_SLICES_DEF);
      depth      = DEPTH_W'(slice_pos + 1);
      at         = row_pos * MAX_COLUMNS_DEF + column_pos;
      first_hit  = (mode == MODE_FIRST_DEPTH) || (mode == MODE_FIRST_VALUE);
      last_col   = column_pos + 1 >= cols;
      last_row   = row_pos + 1 >= rows;
      last_slice = slice_pos + 1 >= slices;

      if (slice_pos == 0) begin
         // The first slice overwrites the entry; a zero is no hit in first-hit modes.
         best_value[at] = v;
         best_depth[at] = (first_hit && v == '0) ? '0 : DEPTH_W'(1);
      end else if (first_hit) begin
         if (v != '0 && best_depth[at] == '0) begin
            best_value[at] = v;
            best_depth[at] = depth;
         end
      end else if (v > best_value[at]) begin
         best_value[at] = v;
         best_depth[at] = depth;
      end

      if (mode == MODE_FIRST_DEPTH || mode == MODE_MAX_DEPTH) begin
         pixel.value = VOXEL_W'(best_depth[at]);
      end else begin
         pixel.value = best_value[at];
      end
      pixel.end_image = last_row && last_col;

      if (!last_col) begin
         column_pos++;
      end else begin
         column_pos = 0;
         if (!last_row) begin
            row_pos++;
         end else begin
            row_pos   = 0;
            slice_pos = last_slice ? 0 : slice_pos + 1;
         end
      end
      return last_slice;
   endfunction

   always @(posedge clock) begin : watch
      pixel_type pixel;
      pixel_type want;
      if (reset) begin
         mode           = MODE_FIRST_DEPTH;
         columns_reg    = CSR_DATA_W'(MAX_COLUMNS_DEF);
         rows_reg       = CSR_DATA_W'(MAX_ROWS_DEF);
         slices_reg     = DEPTH_W'(MAX_SLICES_DEF);
         column_pos     = 0;
         row_pos        = 0;
         slice_pos      = 0;
         mismatch_count = 0;
         expected_pixels.delete();
      end else begin
         // Results are taken before the voxel beat of the same edge, so a
         // result can never match an expectation made at that very edge.
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch($sformatf("unexpected result beat, value %h end %b",
                                         rsp_projected_value, rsp_end_of_image));
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_projected_value !== want.value) begin
                  report_mismatch($sformatf("projected value %h, expected %h",
                                            rsp_projected_value, want.value));
               end
               if (rsp_end_of_image !== want.end_image) begin
                  report_mismatch($sformatf("end of image %b, expected %b",
                                            rsp_end_of_image, want.end_image));
               end
            end
         end
         if (csr_write) begin
            case (csr_index)
               CSR_MODE:    mode = mode_type'(csr_data[1:0]);
               CSR_COLUMNS: columns_reg = csr_data;
               CSR_ROWS:    rows_reg = csr_data;
               CSR_SLICES:  slices_reg = csr_data[DEPTH_W-1:0];
               default: ;
            endcase
            // Any write, known index or not, starts a new volume.
            column_pos = 0;
            row_pos    = 0;
            slice_pos  = 0;
         end
         if (req_valid && !req_stall) begin
            if (project_voxel(req_voxel_value, pixel)) begin
               expected_pixels.push_back(pixel);
            end
         end
      end
      pixels_outstanding <= expected_pixels.size();
   end

endmodule

@@ verif/volume_axial_projection_test.sv @@
// Testbench top for the axial volume projection: clock, reset, register setup,
// voxel stimulus, receiver stalls and the verdict.
// Depends on vap_pkg, volume_axial_projection and volume_axial_projection_checker.
module volume_axial_projection_test;
   import vap_pkg::*;

   localparam int unsigned RANDOM_VOXELS = 1400;
   localparam int unsigned HOLD_CYCLES   = 200;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned CYCLE_LIMIT   = 1000000;

   logic                   clock;
   logic                   reset;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;
   logic                   req_valid;
   logic                   req_stall;
   logic [VOXEL_W-1:0]     req_voxel_value;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [VOXEL_W-1:0]     rsp_projected_value;
   logic                   rsp_end_of_image;
   int unsigned            mismatch_count;
   int unsigned            pixels_outstanding;

   bit                     gaps_on;
   int unsigned            holds_asked;
   int unsigned            holds_served;
   int unsigned            voxels_sent;

   volume_axial_projection dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_voxel_value     (req_voxel_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_projected_value (rsp_projected_value),
      .rsp_end_of_image    (rsp_end_of_image)
   );

   volume_axial_projection_checker projection_check (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_voxel_value     (req_voxel_value),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_projected_value (rsp_projected_value),
      .rsp_end_of_image    (rsp_end_of_image),
      .mismatch_count      (mismatch_count),
      .pixels_outstanding  (pixels_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Zeros and small values are frequent so that ties and missing hits occur.
   function automatic logic [VOXEL_W-1:0] pick_voxel();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 25) return '0;
      if (r < 55) return VOXEL_W'($urandom_range(1, 4));
      if (r < 60) return '1;
      return VOXEL_W'($urandom);
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input mode_type m, input int unsigned cols,
                            input int unsigned rows, input int unsigned slices);
      write_reg(CSR_MODE, CSR_DATA_W'($urandom_range(0, 127) << 2) | CSR_DATA_W'(m));
      write_reg(CSR_COLUMNS, CSR_DATA_W'(cols));
      write_reg(CSR_ROWS, CSR_DATA_W'(rows));
      // Bit 8 of the data lies outside the slice register.
      write_reg(CSR_SLICES,
                CSR_DATA_W'(slices) | (CSR_DATA_W'($urandom_range(0, 1)) << DEPTH_W));
   endtask

   task automatic send_voxel(input logic [VOXEL_W-1:0] voxel);
      int unsigned gap;
      gap = gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_voxel_value <= voxel;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_random(input int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         send_voxel(pick_voxel());
      end
      voxels_sent += count;
   endtask

   // Drains every pending result, then lets beats that produce nothing finish.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pixels_outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_volume(input int unsigned cols, input int unsigned rows,
                             input int unsigned slices, input int unsigned count);
      configure(mode_type'($urandom_range(MODE_FIRST_DEPTH, MODE_MAX_VALUE)),
                cols, rows, slices);
      gaps_on = $urandom_range(0, 3) != 0;
      send_random(count);
      wait_idle();
   endtask

   // Receiver: random stall stretches, plus a long hold whenever one is asked.
   initial begin : receiver
      bit          stalled;
      int unsigned left;
      int unsigned gap;
      rsp_stall <= 1'b0;
      stalled = 1'b0;
      left    = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (holds_served != holds_asked) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_served++;
            stalled = 1'b1;
            left    = 0;
         end else if (left > 0) begin
            left--;
         end else if (stalled) begin
            rsp_stall <= 1'b0;
            stalled = 1'b0;
            left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 6);
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               stalled = 1'b1;
               left    = gap - 1;
            end else begin
               left = $urandom_range(0, 6);
            end
         end
      end
   end

   initial begin : stimulus
      mode_type    m;
      int unsigned cols;
      int unsigned rows;
      int unsigned slices;
      int unsigned volume;
      int unsigned count;
      reset           <= 1'b1;
      csr_write       <= 1'b0;
      csr_index       <= '0;
      csr_data        <= '0;
      req_valid       <= 1'b0;
      req_voxel_value <= '0;
      gaps_on      = 1'b1;
      holds_asked  = 0;
      voxels_sent  = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset dimensions: these beats stay in the first slice and give nothing.
      send_voxel('1);
      send_voxel('0);
      wait_idle();

      // Two pixels over three slices in every mode. The left pixel never hits;
      // the right one first hits at full scale in slice two and ties in slice
      // three, where the earliest maximum must hold.
      m = m.first();
      do begin
         configure(m, 2, 1, 3);
         send_voxel('0);
         send_voxel('0);
         send_voxel('0);
         send_voxel('1);
         send_voxel('0);
         send_voxel('1);
         wait_idle();
         m = m.next();
      end while (m != m.first());

      // The receiver holds off while single-slice beats keep coming, so the
      // block has to stall its input.
      configure(MODE_MAX_VALUE, 8, 4, 1);
      gaps_on = 1'b0;
      holds_asked++;
      send_random(64);
      wait_idle();

      // Extreme dimensions, including values beyond the limits and zeros.
      run_volume($urandom_range(256, 511), 1, 1, 256);
      run_volume(1, $urandom_range(256, 511), 1, 256);
      run_volume(1, 1, 255, 255);
      run_volume(0, 0, 0, 4);
      cols   = 1;
      rows   = 1;
      slices = 1;

      while (voxels_sent < RANDOM_VOXELS) begin
         case ($urandom_range(0, 5))
            0: begin
               // A write to an unused index restarts the volume alone.
               write_reg(CSR_INDEX_W'($urandom_range(CSR_SLICES + 1, (1 << CSR_INDEX_W) - 1)),
                         CSR_DATA_W'($urandom));
            end
            1: begin
               write_reg(CSR_MODE, CSR_DATA_W'($urandom_range(MODE_FIRST_DEPTH, MODE_MAX_VALUE)));
            end
            default: begin
               cols   = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
               rows   = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
               slices = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
               configure(mode_type'($urandom_range(MODE_FIRST_DEPTH, MODE_MAX_VALUE)),
                         cols, rows, slices);
               cols   = (cols == 0) ? 1 : cols;
               rows   = (rows == 0) ? 1 : rows;
               slices = (slices == 0) ? 1 : slices;
            end
         endcase
         // Whole volumes, sometimes followed by a partial one that the next
         // register write cuts short.
         volume = cols * rows * slices;
         count  = volume * $urandom_range(1, 2);
         if ($urandom_range(0, 3) == 0) count += $urandom_range(1, volume);
         gaps_on = $urandom_range(0, 3) != 0;
         send_random(count);
         wait_idle();
      end

      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/vap_pkg.sv
rtl/core/vap_scan.sv
rtl/core/vap_pixel_mem.sv
rtl/core/volume_axial_projection.sv
verif/volume_axial_projection_checker.sv
verif/volume_axial_projection_test.sv
